### rtl/lcps_pkg.sv
// Shared types, codes and the CRC-32 byte update for the log prefix scanner.
`timescale 1ns / 1ps

package lcps_pkg;

    // Parsing phases of the scanner.
    typedef enum logic [2:0] {
        PH_HDR,
        PH_LEN,
        PH_NAME,
        PH_OP,
        PH_KLEN,
        PH_KEY,
        PH_CRC
    } phase_t;

    // Summary status codes.
    localparam logic [1:0] ST_CLEAN   = 2'd0;
    localparam logic [1:0] ST_HEADER  = 2'd1;
    localparam logic [1:0] ST_CORRUPT = 2'd2;
    localparam logic [1:0] ST_TORN    = 2'd3;

    // Configuration register indexes.
    localparam int unsigned CFG_IDX_BITS = 2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_ADD    = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_DELETE = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_COMMIT = 2'd2;

    // Header layout.
    localparam int unsigned HDR_BYTES = 16;
    localparam int unsigned HDR_CRC_START = 12;
    localparam logic [7:0] MAGIC [4] = '{8'h44, 8'h54, 8'h58, 8'h4C};

    // Bytes after the op byte before a bad op is declared corrupt.
    localparam logic [3:0] TAIL_LIMIT = 4'd8;

    // Event queue depth.
    localparam int unsigned QDEPTH = 4;
    localparam int unsigned QPTR_BITS = $clog2(QDEPTH);

    localparam logic [31:0] CRC_POLY = 32'hEDB88320;
    localparam logic [15:0] COMMIT_END_RESET = 16'd16;

    // One transaction worth of results: a record, a summary, or both.
    typedef struct packed {
        logic        rec_v;
        logic [7:0]  op;
        logic [15:0] name_len;
        logic [31:0] key_len;
        logic [31:0] rec_end;
        logic [31:0] commit_end;
        logic        sum_v;
        logic [1:0]  status;
    } event_t;

    // Reflected CRC-32 update over one byte.
    function automatic logic [31:0] crc_byte(input logic [31:0] c_in, input logic [7:0] b);
        logic [31:0] c;
        c = c_in ^ {24'd0, b};
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

### rtl/lcps_scan.sv
// Front end: accepts log bytes, tracks framing and CRC, and forms result events.
`timescale 1ns / 1ps

module lcps_scan #(
    parameter int OFFSET_BITS = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                wr_en,
    input  logic [1:0]          wr_index,
    input  logic [7:0]          wr_data,
    input  logic                acc,
    input  logic [7:0]          data_byte,
    input  logic                last_byte,
    output logic                push,
    output lcps_pkg::event_t    ev
);
    import lcps_pkg::*;

    logic [7:0] add_reg, del_reg, com_reg;

    phase_t                 phase_reg, phase_next;
    logic [OFFSET_BITS-1:0] off_reg, off_next;
    logic [31:0]            fc_reg, fc_next;
    logic [15:0]            nl_reg, nl_next;
    logic [31:0]            kl_reg, kl_next;
    logic [7:0]             op_reg, op_next;
    logic [31:0]            crc_reg, crc_next;
    logic [31:0]            scrc_reg, scrc_next;
    logic [OFFSET_BITS-1:0] cend_reg, cend_next;
    logic                   stop_reg, stop_next;
    logic [1:0]             why_reg, why_next;
    logic                   opbad_reg, opbad_next;
    logic [3:0]             tail_reg, tail_next;

    logic                   start_rec, bad_tail, rec_done;
    logic [1:0]             sum_status;
    logic [OFFSET_BITS+31:0] wide_off, wide_cend;

    // Opcode registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            add_reg <= 8'd1;
            del_reg <= 8'd2;
            com_reg <= 8'd3;
        end
        else if (wr_en)
        begin
            case (wr_index)
                CFG_ADD:    add_reg <= wr_data;
                CFG_DELETE: del_reg <= wr_data;
                CFG_COMMIT: com_reg <= wr_data;
                default:    ;
            endcase
        end
    end

    // Byte parser.
    always_comb
    begin
        phase_next = phase_reg;
        off_next   = off_reg;
        fc_next    = fc_reg;
        nl_next    = nl_reg;
        kl_next    = kl_reg;
        op_next    = op_reg;
        crc_next   = crc_reg;
        scrc_next  = scrc_reg;
        cend_next  = cend_reg;
        stop_next  = stop_reg;
        why_next   = why_reg;
        opbad_next = opbad_reg;
        tail_next  = tail_reg;
        start_rec  = 1'b0;
        bad_tail   = 1'b0;
        rec_done   = 1'b0;
        sum_status = ST_CLEAN;

        if (acc && !stop_reg)
        begin
            if (off_reg == {OFFSET_BITS{1'b1}})
            begin
                stop_next = 1'b1;
                why_next  = ST_CORRUPT;
            end
            else
            begin
                off_next = off_reg + 1'b1;
                // Bytes after the op byte count toward the bad-op decision.
                if (phase_reg == PH_KLEN || phase_reg == PH_KEY || phase_reg == PH_CRC)
                begin
                    if (tail_reg < TAIL_LIMIT)
                    begin
                        tail_next = tail_reg + 4'd1;
                        if (tail_next == TAIL_LIMIT && opbad_reg)
                        begin
                            bad_tail  = 1'b1;
                            stop_next = 1'b1;
                            why_next  = ST_CORRUPT;
                        end
                    end
                end
                case (phase_reg)
                    PH_HDR:
                    begin
                        if (fc_reg < HDR_CRC_START)
                            crc_next = crc_byte(crc_reg, data_byte);
                        if (fc_reg < 32'd4 && data_byte != MAGIC[fc_reg[1:0]])
                        begin
                            stop_next = 1'b1;
                            why_next  = ST_HEADER;
                        end
                        else if (fc_reg >= 32'd4 && fc_reg < 32'd8 &&
                                 data_byte != ((fc_reg == 32'd4) ? 8'd1 : 8'd0))
                        begin
                            stop_next = 1'b1;
                            why_next  = ST_HEADER;
                        end
                        else
                        begin
                            if (fc_reg >= HDR_CRC_START)
                                scrc_next = {data_byte, scrc_reg[31:8]};
                            fc_next = fc_reg + 32'd1;
                            if (fc_next == HDR_BYTES)
                            begin
                                if (scrc_next != ~crc_next)
                                begin
                                    stop_next = 1'b1;
                                    why_next  = ST_HEADER;
                                end
                                else
                                    start_rec = 1'b1;
                            end
                        end
                    end
                    PH_LEN:
                    begin
                        crc_next = crc_byte(crc_reg, data_byte);
                        if (fc_reg[0])
                            nl_next = {data_byte, nl_reg[7:0]};
                        else
                            nl_next = {nl_reg[15:8], data_byte};
                        fc_next = fc_reg + 32'd1;
                        if (fc_next >= 32'd2)
                        begin
                            fc_next    = '0;
                            phase_next = (nl_next != '0) ? PH_NAME : PH_OP;
                        end
                    end
                    PH_NAME:
                    begin
                        crc_next = crc_byte(crc_reg, data_byte);
                        fc_next  = fc_reg + 32'd1;
                        if (fc_next >= {16'd0, nl_reg})
                        begin
                            fc_next    = '0;
                            phase_next = PH_OP;
                        end
                    end
                    PH_OP:
                    begin
                        crc_next   = crc_byte(crc_reg, data_byte);
                        op_next    = data_byte;
                        opbad_next = !(data_byte == add_reg || data_byte == del_reg ||
                                       data_byte == com_reg) ||
                                     (data_byte == com_reg && nl_reg != '0);
                        tail_next  = '0;
                        fc_next    = '0;
                        phase_next = PH_KLEN;
                    end
                    PH_KLEN:
                    begin
                        crc_next = crc_byte(crc_reg, data_byte);
                        case (fc_reg[1:0])
                            2'd0:    kl_next = {kl_reg[31:8], data_byte};
                            2'd1:    kl_next = {kl_reg[31:16], data_byte, kl_reg[7:0]};
                            2'd2:    kl_next = {kl_reg[31:24], data_byte, kl_reg[15:0]};
                            default: kl_next = {data_byte, kl_reg[23:0]};
                        endcase
                        fc_next = fc_reg + 32'd1;
                        if (fc_next >= 32'd4)
                        begin
                            fc_next    = '0;
                            scrc_next  = '0;
                            phase_next = (kl_next != '0) ? PH_KEY : PH_CRC;
                        end
                    end
                    PH_KEY:
                    begin
                        crc_next = crc_byte(crc_reg, data_byte);
                        fc_next  = fc_reg + 32'd1;
                        if (!bad_tail && fc_next >= kl_reg)
                        begin
                            fc_next    = '0;
                            phase_next = PH_CRC;
                        end
                    end
                    default:
                    begin
                        scrc_next = {data_byte, scrc_reg[31:8]};
                        fc_next   = fc_reg + 32'd1;
                        if (!bad_tail && fc_next >= 32'd4)
                        begin
                            if (scrc_next != ~crc_reg)
                            begin
                                stop_next = 1'b1;
                                why_next  = ST_CORRUPT;
                            end
                            else
                            begin
                                if (op_reg == com_reg)
                                    cend_next = off_next;
                                rec_done  = 1'b1;
                                start_rec = 1'b1;
                            end
                        end
                    end
                endcase
            end
        end

        // Summary status from the state left by this byte.
        if (stop_next)
            sum_status = why_next;
        else if (phase_next == PH_HDR && !start_rec)
            sum_status = ST_HEADER;
        else if (start_rec || (phase_next == PH_LEN && fc_next == '0))
            sum_status = ST_CLEAN;
        else
            sum_status = ST_TORN;

        // Record start clears the per-record fields.
        if (start_rec)
        begin
            phase_next = PH_LEN;
            fc_next    = '0;
            nl_next    = '0;
            kl_next    = '0;
            op_next    = '0;
            crc_next   = '1;
            scrc_next  = '0;
            opbad_next = 1'b0;
            tail_next  = '0;
        end

        // End of file returns the scanner to its reset state.
        if (acc && last_byte)
        begin
            phase_next = PH_HDR;
            off_next   = '0;
            fc_next    = '0;
            nl_next    = '0;
            kl_next    = '0;
            op_next    = '0;
            crc_next   = '1;
            scrc_next  = '0;
            cend_next  = OFFSET_BITS'(COMMIT_END_RESET);
            stop_next  = 1'b0;
            why_next   = ST_CLEAN;
            opbad_next = 1'b0;
            tail_next  = '0;
        end
    end

    // Event formation; offsets are reported in 32 bits.
    assign wide_off  = {32'd0, off_reg + 1'b1};
    assign wide_cend = {32'd0, (rec_done && op_reg == com_reg) ? off_reg + 1'b1 : cend_reg};

    always_comb
    begin
        ev            = '0;
        ev.rec_v      = rec_done;
        ev.op         = op_reg;
        ev.name_len   = nl_reg;
        ev.key_len    = kl_reg;
        ev.rec_end    = wide_off[31:0];
        ev.commit_end = wide_cend[31:0];
        ev.sum_v      = last_byte;
        ev.status     = sum_status;
    end

    assign push = acc && (rec_done || last_byte);

    // Scanner state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HDR;
            off_reg   <= '0;
            fc_reg    <= '0;
            nl_reg    <= '0;
            kl_reg    <= '0;
            op_reg    <= '0;
            crc_reg   <= '1;
            scrc_reg  <= '0;
            cend_reg  <= OFFSET_BITS'(COMMIT_END_RESET);
            stop_reg  <= 1'b0;
            why_reg   <= ST_CLEAN;
            opbad_reg <= 1'b0;
            tail_reg  <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            off_reg   <= off_next;
            fc_reg    <= fc_next;
            nl_reg    <= nl_next;
            kl_reg    <= kl_next;
            op_reg    <= op_next;
            crc_reg   <= crc_next;
            scrc_reg  <= scrc_next;
            cend_reg  <= cend_next;
            stop_reg  <= stop_next;
            why_reg   <= why_next;
            opbad_reg <= opbad_next;
            tail_reg  <= tail_next;
        end
    end

endmodule

### rtl/lcps_queue.sv
// Short event queue between the byte parser and the result emitter.
`timescale 1ns / 1ps

module lcps_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  lcps_pkg::event_t push_ev,
    input  logic             pop,
    output lcps_pkg::event_t head,
    output logic             full,
    output logic             empty
);
    import lcps_pkg::*;

    event_t                entries [QDEPTH];
    logic [QPTR_BITS-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [QPTR_BITS:0]    count_reg;

    assign full  = (count_reg == (QPTR_BITS+1)'(QDEPTH));
    assign empty = (count_reg == '0);
    assign head  = entries[rd_ptr_reg];

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
            entries[wr_ptr_reg] <= push_ev;
    end

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule

### rtl/lcps_emit.sv
// Back end: turns queued events into record and summary transactions.
`timescale 1ns / 1ps

module lcps_emit (
    input  logic             clk,
    input  logic             rst_n,
    input  lcps_pkg::event_t head,
    input  logic             empty,
    output logic             pop,
    output logic             out_valid,
    input  logic             out_stall,
    output logic             kind,
    output logic [7:0]       op_code,
    output logic [15:0]      name_length,
    output logic [31:0]      key_length,
    output logic [31:0]      record_end,
    output logic [31:0]      commit_offset,
    output logic [1:0]       status,
    output logic             final_res
);
    import lcps_pkg::*;

    logic valid_reg;
    logic sent_rec_reg;
    logic load;
    logic send_rec;

    assign load     = !empty && (!valid_reg || !out_stall);
    assign send_rec = head.rec_v && !sent_rec_reg;
    assign pop      = load && !(send_rec && head.sum_v);
    assign out_valid = valid_reg;

    // Output control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= 1'b0;
            sent_rec_reg <= 1'b0;
        end
        else
        begin
            if (load)
                valid_reg <= 1'b1;
            else if (!out_stall)
                valid_reg <= 1'b0;
            if (load)
                sent_rec_reg <= send_rec && head.sum_v;
        end
    end

    // Output payload.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            commit_offset <= head.commit_end;
            if (send_rec)
            begin
                kind        <= 1'b0;
                op_code     <= head.op;
                name_length <= head.name_len;
                key_length  <= head.key_len;
                record_end  <= head.rec_end;
                status      <= ST_CLEAN;
                final_res   <= !head.sum_v;
            end
            else
            begin
                kind        <= 1'b1;
                op_code     <= '0;
                name_length <= '0;
                key_length  <= '0;
                record_end  <= '0;
                status      <= head.status;
                final_res   <= 1'b1;
            end
        end
    end

endmodule

### rtl/log_committed_prefix_scanner.sv
// Top level of the transaction log committed-prefix scanner.
`timescale 1ns / 1ps

// The scanner takes one log byte per cycle, checks the 16-byte header and
// deframes records, reporting each valid record and one summary transaction on
// the byte marked last. A byte is accepted every cycle while the four-entry
// event queue has room; the result side delivers one transaction per cycle
// while not stalled; only a final byte that also completes a record yields two
// transactions. Results pass through the event queue and the output register.
module log_committed_prefix_scanner #(
    parameter int OFFSET_BITS = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        wr_en,
    input  logic [1:0]  wr_index,
    input  logic [7:0]  wr_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic        last_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        kind,
    output logic [7:0]  op_code,
    output logic [15:0] name_length,
    output logic [31:0] key_length,
    output logic [31:0] record_end,
    output logic [31:0] commit_offset,
    output logic [1:0]  status,
    output logic        final_res
);
    import lcps_pkg::*;

    logic   acc, push, pop, full, empty;
    event_t ev, head;

    assign in_stall = full;
    assign acc      = in_valid && !full;

    lcps_scan #(.OFFSET_BITS(OFFSET_BITS)) u_scan (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_en     (wr_en),
        .wr_index  (wr_index),
        .wr_data   (wr_data),
        .acc       (acc),
        .data_byte (data_byte),
        .last_byte (last_byte),
        .push      (push),
        .ev        (ev)
    );

    lcps_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .push_ev (ev),
        .pop     (pop),
        .head    (head),
        .full    (full),
        .empty   (empty)
    );

    lcps_emit u_emit (
        .clk           (clk),
        .rst_n         (rst_n),
        .head          (head),
        .empty         (empty),
        .pop           (pop),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .kind          (kind),
        .op_code       (op_code),
        .name_length   (name_length),
        .key_length    (key_length),
        .record_end    (record_end),
        .commit_offset (commit_offset),
        .status        (status),
        .final_res     (final_res)
    );

endmodule

### tb/lcps_scan_checker.sv
// Checker for the log prefix scanner: predicts results per accepted byte and compares them.
`timescale 1ns / 1ps

module lcps_scan_checker
    import lcps_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        wr_en,
    input  logic [1:0]  wr_index,
    input  logic [7:0]  wr_data,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic        last_byte,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic        kind,
    input  logic [7:0]  op_code,
    input  logic [15:0] name_length,
    input  logic [31:0] key_length,
    input  logic [31:0] record_end,
    input  logic [31:0] commit_offset,
    input  logic [1:0]  status,
    input  logic        final_res,
    output int          pending,
    output int          errors
);

    typedef struct {
        logic        kind;
        logic [7:0]  op;
        logic [15:0] nlen;
        logic [31:0] klen;
        logic [31:0] rend;
        logic [31:0] cend;
        logic [1:0]  st;
        logic        fin;
    } scan_result_t;

    scan_result_t result_q[$];

    // Opcode registers as the scanner should hold them.
    logic [7:0] op_add, op_del, op_cmt;

    // Scan state.
    phase_t      ph;
    logic [31:0] offs;
    logic [31:0] fcnt;
    logic [15:0] nlen;
    logic [31:0] klen;
    logic [7:0]  opr;
    logic [31:0] crc;
    logic [31:0] scrc;
    logic [31:0] cend;
    logic        stopped;
    logic [1:0]  why;
    logic        opbad;
    logic [3:0]  tail;

    assign pending = result_q.size();

    function automatic logic [31:0] crc_step(input logic [31:0] c_in, input logic [7:0] b);
        logic [31:0] c;
        c = c_in ^ {24'd0, b};
        repeat (8) c = c[0] ? ((c >> 1) ^ 32'hEDB88320) : (c >> 1);
        return c;
    endfunction

    task automatic new_record();
        ph = PH_LEN;
        fcnt = 0;
        nlen = 0;
        klen = 0;
        opr = 0;
        crc = 32'hFFFFFFFF;
        scrc = 0;
        opbad = 1'b0;
        tail = 0;
    endtask

    task automatic new_file();
        new_record();
        ph = PH_HDR;
        offs = 0;
        cend = 32'd16;
        stopped = 1'b0;
        why = ST_CLEAN;
    endtask

    function automatic void halt_scan(input logic [1:0] r);
        stopped = 1'b1;
        why = r;
    endfunction

    // Counts a byte after the op byte; returns 1 when a bad op is now declared.
    function automatic bit count_tail();
        if (tail < 4'd8) begin
            tail++;
            if (tail == 4'd8 && opbad) begin
                halt_scan(ST_CORRUPT);
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    // Advances the scan by one counted byte and queues a record result if one completes.
    task automatic scan_byte(input logic [7:0] b, output bit got_rec);
        scan_result_t r;
        got_rec = 1'b0;
        case (ph)
            PH_HDR: begin
                if (fcnt < 12) crc = crc_step(crc, b);
                if (fcnt < 4 && b != MAGIC[fcnt]) begin
                    halt_scan(ST_HEADER);
                    return;
                end
                if (fcnt >= 4 && fcnt < 8 && b != ((fcnt == 4) ? 8'd1 : 8'd0)) begin
                    halt_scan(ST_HEADER);
                    return;
                end
                if (fcnt >= 12) scrc = (scrc >> 8) | ({24'd0, b} << 24);
                fcnt++;
                if (fcnt == 16) begin
                    if (scrc != ~crc) begin
                        halt_scan(ST_HEADER);
                        return;
                    end
                    new_record();
                end
            end
            PH_LEN: begin
                crc = crc_step(crc, b);
                if (fcnt[0]) nlen[15:8] = b;
                else nlen[7:0] = b;
                fcnt++;
                if (fcnt >= 2) begin
                    fcnt = 0;
                    ph = (nlen != 0) ? PH_NAME : PH_OP;
                end
            end
            PH_NAME: begin
                crc = crc_step(crc, b);
                fcnt++;
                if (fcnt >= nlen) begin
                    fcnt = 0;
                    ph = PH_OP;
                end
            end
            PH_OP: begin
                crc = crc_step(crc, b);
                opr = b;
                opbad = !(b == op_add || b == op_del || b == op_cmt)
                        || (b == op_cmt && nlen != 0);
                tail = 0;
                fcnt = 0;
                ph = PH_KLEN;
            end
            PH_KLEN: begin
                crc = crc_step(crc, b);
                klen[8*fcnt[1:0] +: 8] = b;
                fcnt++;
                void'(count_tail());
                if (fcnt >= 4) begin
                    fcnt = 0;
                    scrc = 0;
                    ph = (klen != 0) ? PH_KEY : PH_CRC;
                end
            end
            PH_KEY: begin
                crc = crc_step(crc, b);
                fcnt++;
                if (count_tail()) return;
                if (fcnt >= klen) begin
                    fcnt = 0;
                    ph = PH_CRC;
                end
            end
            default: begin
                scrc = (scrc >> 8) | ({24'd0, b} << 24);
                fcnt++;
                if (count_tail()) return;
                if (fcnt < 4) return;
                if (scrc != ~crc) begin
                    halt_scan(ST_CORRUPT);
                    return;
                end
                if (opr == op_cmt) cend = offs;
                r = '{1'b0, opr, nlen, klen, offs, cend, ST_CLEAN, 1'b0};
                result_q.push_back(r);
                got_rec = 1'b1;
                new_record();
            end
        endcase
    endtask

    task automatic check_field(input string fname, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t: %s mismatch: expected %0h, actual %0h", $time, fname, exp_v, act_v);
            errors++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        scan_result_t r;
        bit got_rec;
        if (!rst_n) begin
            op_add = 8'd1;
            op_del = 8'd2;
            op_cmt = 8'd3;
            new_file();
            result_q.delete();
            errors = 0;
        end else begin
            // Register writes.
            if (wr_en) begin
                case (wr_index)
                    CFG_ADD:    op_add = wr_data;
                    CFG_DELETE: op_del = wr_data;
                    CFG_COMMIT: op_cmt = wr_data;
                    default: ;
                endcase
            end

            // Input transaction: predict.
            if (in_valid && !in_stall) begin
                got_rec = 1'b0;
                if (!stopped) begin
                    if (offs == 32'hFFFFFFFF) halt_scan(ST_CORRUPT);
                    else begin
                        offs++;
                        scan_byte(data_byte, got_rec);
                    end
                end
                if (last_byte) begin
                    r = '{1'b1, 8'd0, 16'd0, 32'd0, 32'd0, cend, ST_CLEAN, 1'b1};
                    if (stopped) r.st = why;
                    else if (ph == PH_HDR) r.st = ST_HEADER;
                    else if (ph == PH_LEN && fcnt == 0) r.st = ST_CLEAN;
                    else r.st = ST_TORN;
                    result_q.push_back(r);
                    new_file();
                end else if (got_rec) begin
                    result_q[$].fin = 1'b1;
                end
            end

            // Output transaction: compare with the oldest expectation.
            if (out_valid && !out_stall) begin
                if (result_q.size() == 0) begin
                    $display("%0t: unexpected result transaction, kind %0d", $time, kind);
                    errors++;
                end else begin
                    r = result_q.pop_front();
                    check_field("kind", r.kind, kind);
                    check_field("op_code", r.op, op_code);
                    check_field("name_length", r.nlen, name_length);
                    check_field("key_length", r.klen, key_length);
                    check_field("record_end", r.rend, record_end);
                    check_field("commit_offset", r.cend, commit_offset);
                    check_field("status", r.st, status);
                    check_field("final_res", r.fin, final_res);
                end
            end
        end
    end

endmodule

### tb/tb_log_committed_prefix_scanner.sv
// Testbench top for the log prefix scanner: builds log files, drives them and gives the verdict.
`timescale 1ns / 1ps

module tb_log_committed_prefix_scanner;
    import lcps_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        wr_en;
    logic [1:0]  wr_index;
    logic [7:0]  wr_data;
    logic        in_valid;
    logic        in_stall;
    logic [7:0]  data_byte;
    logic        last_byte;
    logic        out_valid;
    logic        out_stall;
    logic        kind;
    logic [7:0]  op_code;
    logic [15:0] name_length;
    logic [31:0] key_length;
    logic [31:0] record_end;
    logic [31:0] commit_offset;
    logic [1:0]  status;
    logic        final_res;
    int          pending;
    int          errors;

    // Shared control between stimulus and the result side.
    bit          quiet;
    bit          hold_req;
    logic [7:0]  cur_add, cur_del, cur_cmt;
    logic [7:0]  file_q[$];
    int          bytes_sent;

    log_committed_prefix_scanner dut (.*);

    lcps_scan_checker chk (.*);

    initial clk = 1'b0;
    always #6 clk = ~clk;

    // Watchdog.
    initial
    begin
        #8ms;
        $display("[log_committed_prefix_scanner] ERROR");
        $finish;
    end

    // Result side stall: random bursts except when quiet, and one long hold on request.
    initial
    begin
        int idle_left;
        int hold_left;
        idle_left = 0;
        hold_left = 0;
        out_stall = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_req && hold_left == 0) begin
                hold_req = 1'b0;
                hold_left = 200;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_stall <= 1'b1;
            end else if (quiet) begin
                out_stall <= 1'b0;
            end else if (idle_left > 0) begin
                idle_left--;
                out_stall <= 1'b1;
            end else if ($urandom_range(0, 7) == 0) begin
                idle_left = $urandom_range(0, 14);
                out_stall <= 1'b1;
            end else begin
                out_stall <= 1'b0;
            end
        end
    end

    function automatic logic [31:0] log_crc(input logic [7:0] bytes[$], input int from,
                                            input int upto);
        logic [31:0] c;
        c = 32'hFFFFFFFF;
        for (int i = from; i < upto; i++) begin
            c ^= {24'd0, bytes[i]};
            repeat (8) c = c[0] ? ((c >> 1) ^ 32'hEDB88320) : (c >> 1);
        end
        return ~c;
    endfunction

    task automatic push_word(input logic [31:0] w, input int n);
        for (int i = 0; i < n; i++) file_q.push_back(w[8*i +: 8]);
    endtask

    // Header; fault 0 none, 1 magic, 2 version, 3 header CRC.
    task automatic add_header(input int fault);
        int base;
        base = file_q.size();
        for (int i = 0; i < 4; i++) file_q.push_back(MAGIC[i]);
        push_word(32'd1, 4);
        push_word($urandom, 4);
        if (fault == 1) file_q[base + $urandom_range(0, 3)] ^= 8'h01 << $urandom_range(0, 7);
        if (fault == 2) file_q[base + $urandom_range(4, 7)] ^= 8'h01 << $urandom_range(0, 7);
        push_word(log_crc(file_q, base, base + 12) ^ ((fault == 3) ? 32'h100 : 32'h0), 4);
    endtask

    // One record; bad_crc flips the stored CRC.
    task automatic add_record(input int nl, input logic [7:0] op, input int kl,
                              input bit bad_crc);
        int base;
        base = file_q.size();
        push_word(nl, 2);
        repeat (nl) file_q.push_back(8'($urandom));
        file_q.push_back(op);
        push_word(kl, 4);
        repeat (kl) file_q.push_back(8'($urandom));
        push_word(log_crc(file_q, base, file_q.size()) ^ (bad_crc ? 32'h8000_0000 : 32'h0), 4);
    endtask

    // Sends the built file, marking its final byte, and empties the buffer.
    task automatic send_file();
        int n;
        for (int i = 0; i < file_q.size(); i++) begin
            if (!quiet && $urandom_range(0, 7) == 0) begin
                n = $urandom_range(1, 15);
                @(negedge clk);
                in_valid <= 1'b0;
                repeat (n - 1) @(negedge clk);
            end
            @(negedge clk);
            in_valid <= 1'b1;
            data_byte <= file_q[i];
            last_byte <= (i == file_q.size() - 1);
            do @(posedge clk); while (in_stall);
            bytes_sent++;
        end
        @(negedge clk);
        in_valid <= 1'b0;
        file_q.delete();
    endtask

    task automatic drain();
        while (pending != 0) @(posedge clk);
        repeat (6) @(negedge clk);
    endtask

    task automatic set_opcodes(input logic [7:0] a, input logic [7:0] d, input logic [7:0] c);
        drain();
        wr_en <= 1'b1;
        wr_index <= CFG_ADD;
        wr_data <= a;
        @(negedge clk);
        wr_index <= CFG_DELETE;
        wr_data <= d;
        @(negedge clk);
        wr_index <= CFG_COMMIT;
        wr_data <= c;
        @(negedge clk);
        wr_en <= 1'b0;
        cur_add = a;
        cur_del = d;
        cur_cmt = c;
    endtask

    function automatic logic [7:0] pick_op();
        case ($urandom_range(0, 2))
            0: return cur_add;
            1: return cur_del;
            default: return cur_cmt;
        endcase
    endfunction

    // Random file: mostly well-formed records, some faults and torn ends.
    task automatic random_file();
        int nrec;
        int nl;
        int kl;
        logic [7:0] op;
        add_header(($urandom_range(0, 11) == 0) ? $urandom_range(1, 3) : 0);
        nrec = $urandom_range(0, 6);
        for (int r = 0; r < nrec; r++) begin
            op = pick_op();
            nl = (op == cur_cmt && $urandom_range(0, 5) != 0) ? 0 : $urandom_range(0, 4);
            if ($urandom_range(0, 40) == 0) nl = $urandom_range(256, 300);
            kl = $urandom_range(0, 6);
            if ($urandom_range(0, 14) == 0) op = 8'($urandom);
            add_record(nl, op, kl, $urandom_range(0, 14) == 0);
        end
        if ($urandom_range(0, 9) == 0)
            file_q[$urandom_range(0, file_q.size() - 1)] ^= 8'($urandom);
        if ($urandom_range(0, 5) == 0)
            repeat ($urandom_range(1, 10)) if (file_q.size() > 1) void'(file_q.pop_back());
        if ($urandom_range(0, 15) == 0)
            repeat ($urandom_range(1, 12)) file_q.push_back(8'($urandom));
        send_file();
    endtask

    initial
    begin
        int nfile;
        quiet = 1'b0;
        hold_req = 1'b0;
        bytes_sent = 0;
        rst_n = 1'b0;
        wr_en = 1'b0;
        wr_index = CFG_ADD;
        wr_data = 8'd0;
        in_valid = 1'b0;
        data_byte = 8'd0;
        last_byte = 1'b0;
        cur_add = 8'd1;
        cur_del = 8'd2;
        cur_cmt = 8'd3;
        repeat (2) @(negedge clk);
        rst_n = 1'b1;

        // Directed: every op, empty name and key, commit with a name, unknown op,
        // bad record CRC, header faults, tiny files, torn tails, bytes after a stop.
        add_header(0);
        send_file();
        add_header(0);
        add_record(0, cur_add, 0, 0);
        add_record(3, cur_del, 2, 0);
        add_record(0, cur_cmt, 1, 0);
        add_record(0, 8'hFF, 0, 0);
        send_file();
        add_header(0);
        add_record(2, cur_cmt, 0, 0);
        add_record(0, cur_add, 0, 0);
        send_file();
        add_header(0);
        add_record(0, cur_cmt, 0, 0);
        add_record(1, cur_add, 1, 1);
        repeat (5) file_q.push_back(8'h00);
        send_file();
        for (int f = 1; f <= 3; f++) begin
            add_header(f);
            send_file();
        end
        file_q.push_back(8'h44);
        send_file();
        add_header(0);
        add_record(0, cur_add, 3, 0);
        repeat (2) void'(file_q.pop_back());
        send_file();
        add_header(0);
        add_record(0, 8'h00, 0, 0);
        repeat (6) void'(file_q.pop_back());
        send_file();

        // Random files over several opcode settings, extremes included.
        nfile = 0;
        for (int phase_i = 0; phase_i < 4; phase_i++) begin
            case (phase_i)
                0: set_opcodes(8'd1, 8'd2, 8'd3);
                1: set_opcodes(8'd0, 8'd255, 8'd128);
                2: set_opcodes(8'd255, 8'd0, 8'd127);
                default: set_opcodes(8'h5A, 8'h5A, 8'h5A);
            endcase
            while (bytes_sent < 450 * (phase_i + 1)) begin
                nfile++;
                if (nfile == 4) hold_req = 1'b1;
                if (phase_i == 3 && bytes_sent > 1600) quiet = 1'b1;
                if (nfile % 9 == 0) drain();
                random_file();
            end
        end

        // Wind down.
        drain();
        repeat (10) @(posedge clk);
        if (errors == 0 && pending == 0)
            $display("[log_committed_prefix_scanner] OK");
        else
            $display("[log_committed_prefix_scanner] ERROR");
        $finish;
    end

endmodule
